/* hw/rtl/sphere_edge_touch_classifier_core_assert.svh */
// Assertion macros shared by the classifier RTL.
`ifndef SPHERE_EDGE_TOUCH_CLASSIFIER_CORE_ASSERT_SVH
`define SPHERE_EDGE_TOUCH_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SETC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("setc assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SETC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("setc assertion failed");

`endif

/* hw/rtl/setc_pkg.sv */
`default_nettype none

package setc_pkg;

    localparam int COORD_W    = 32;
    localparam int DIFF_W     = 33;
    localparam int RAD_W      = 31;
    localparam int NORM_W     = 16;
    localparam int MAG_W      = 31;
    localparam int MSB_W      = 6;
    localparam int RADICAND_W = 64;
    localparam int ROOT_W     = 32;
    localparam int QUO_W      = 15;
    localparam int NUM_W      = 46;
    localparam int PROD_W     = 49;
    localparam int PROJ_W     = 50;
    localparam int RND_W      = 36;
    localparam int SQ_W       = 62;
    localparam int FRAC_N     = 14;
    localparam int HALF_N     = 1 << (FRAC_N - 1);
    // normalized magnitudes land in [2^29, 2^31)
    localparam int NORM_TOP   = 30;
    localparam int NORM_BOT   = 29;

    localparam logic signed [COORD_W-1:0] APART_DIST = -32'sd256;
    localparam logic signed [COORD_W-1:0] DIST_MIN   = {1'b1, {(COORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CLS_APART  = 2'd0,
        CLS_TOUCH  = 2'd1,
        CLS_BEHIND = 2'd2,
        CLS_DEEP   = 2'd3
    } touch_class_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] v3x;
        logic signed [DIFF_W-1:0] v3z;
        logic signed [DIFF_W-1:0] v4x;
        logic signed [DIFF_W-1:0] v4z;
        logic [RAD_W-1:0]         radius;
        logic                     dx_neg;
        logic                     dz_pos;
        logic                     degen;
    } edge_side_t;

    typedef struct packed {
        edge_side_t       edge_info;
        logic [MAG_W-1:0] mag_x;
        logic [MAG_W-1:0] mag_z;
    } len_side_t;

    typedef struct packed {
        touch_class_t              cls;
        logic signed [NORM_W-1:0]  nx;
        logic signed [NORM_W-1:0]  nz;
        logic signed [COORD_W-1:0] distance;
        logic                      need_corner;
        logic                      reject;
    } corner_side_t;

    localparam int LEN_SIDE_W    = $bits(len_side_t);
    localparam int CORNER_SIDE_W = $bits(corner_side_t);
    localparam int SIDE_W = (LEN_SIDE_W > CORNER_SIDE_W) ? LEN_SIDE_W : CORNER_SIDE_W;

endpackage

`default_nettype wire

/* hw/rtl/sphere_edge_touch_classifier_core.sv */
// Sphere against polygon edge contact classifier, XZ plane, Q24.8 coordinates.
// Input channel s_axis_*: one transfer carries a sphere (center, radius) and
// one edge (start and end point). Output channel m_axis_*: one transfer per
// input with the class in tuser and the Q1.14 normal plus Q24.8 distance in
// tdata. cfg_wr_en/cfg_wr_data load behind_margin; write it only while idle.
// Depth: 92 register stages from the input to the output register
// (4 front, 32 length root, 16 divide, 7 classify, 32 corner root, 1 output).
// The length root and corner root each retire one result bit per stage.
// Throughput: one transfer per cycle while the receiver takes results.
// The whole pipeline advances together; when the output register holds a
// result the receiver has not taken, every stage holds and s_axis_tready
// drops, so nothing is lost or repeated. Bubbles travel as invalid stages.
// Reset clears all valid bits and sets behind_margin to zero; data
// registers are not reset.
`default_nettype none

`include "sphere_edge_touch_classifier_core_assert.svh"

module sphere_edge_touch_classifier_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [setc_pkg::RAD_W-1:0]     cfg_wr_data,     // behind_margin
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // center_x[31:0] center_y[63:32] center_z[95:64] radius[126:96]
    // start_x[158:127] start_z[190:159] end_x[222:191] end_z[254:223] pad[255]
    input  logic [255:0]                   s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // normal_x[15:0] normal_z[31:16] distance[63:32]
    output logic [63:0]                    m_axis_tdata,
    // touch_class[1:0]
    output logic [1:0]                     m_axis_tuser
);

    localparam int SIDE_W = setc_pkg::SIDE_W;
    localparam int LSW    = setc_pkg::LEN_SIDE_W;
    localparam int CSW    = setc_pkg::CORNER_SIDE_W;
    localparam int QW     = setc_pkg::ROOT_W;
    localparam int CW     = setc_pkg::COORD_W;

    logic                           en;
    logic [setc_pkg::RAD_W-1:0]     behind_margin_reg;

    logic                           front_valid;
    logic [setc_pkg::RADICAND_W-1:0] front_radicand;
    setc_pkg::len_side_t            front_side;

    logic                           len_valid;
    logic [QW-1:0]                  len_root;
    logic [QW:0]                    len_rem;
    logic [SIDE_W-1:0]              len_side_bits;
    setc_pkg::len_side_t            len_side;

    logic                           div_valid;
    logic [setc_pkg::QUO_W-1:0]     div_mx, div_mz;
    setc_pkg::edge_side_t           div_side;

    logic                           back_valid;
    logic [setc_pkg::RADICAND_W-1:0] back_radicand;
    setc_pkg::corner_side_t         back_side;

    logic                           root_valid;
    logic [QW-1:0]                  corner_root;
    logic [QW:0]                    corner_rem;
    logic [SIDE_W-1:0]              corner_side_bits;
    setc_pkg::corner_side_t         corner_side;

    setc_pkg::corner_side_t         result_next;
    logic                           out_valid_reg;
    setc_pkg::touch_class_t         out_cls_reg;
    logic signed [setc_pkg::NORM_W-1:0] out_nx_reg, out_nz_reg;
    logic signed [CW-1:0]           out_dist_reg;

    // Advance the whole pipeline unless a result waits in the output register.
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            behind_margin_reg <= '0;
        else if (cfg_wr_en)
            behind_margin_reg <= cfg_wr_data;
    end

    setc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (s_axis_tvalid),
        .center_x     (s_axis_tdata[31:0]),
        .center_z     (s_axis_tdata[95:64]),
        .radius       (s_axis_tdata[126:96]),
        .start_x      (s_axis_tdata[158:127]),
        .start_z      (s_axis_tdata[190:159]),
        .end_x        (s_axis_tdata[222:191]),
        .end_z        (s_axis_tdata[254:223]),
        .out_valid    (front_valid),
        .out_radicand (front_radicand),
        .out_side     (front_side)
    );

    // edge length
    setc_isqrt u_len_root (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (front_valid),
        .in_radicand (front_radicand),
        .in_side     (SIDE_W'(front_side)),
        .out_valid   (len_valid),
        .out_root    (len_root),
        .out_rem     (len_rem),
        .out_side    (len_side_bits)
    );

    assign len_side = setc_pkg::len_side_t'(len_side_bits[LSW-1:0]);

    setc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (len_valid),
        .in_len    (len_root),
        .in_side   (len_side),
        .out_valid (div_valid),
        .out_mx    (div_mx),
        .out_mz    (div_mz),
        .out_side  (div_side)
    );

    setc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (div_valid),
        .in_mx         (div_mx),
        .in_mz         (div_mz),
        .in_side       (div_side),
        .behind_margin (behind_margin_reg),
        .out_valid     (back_valid),
        .out_radicand  (back_radicand),
        .out_side      (back_side)
    );

    // corner distance
    setc_isqrt u_corner_root (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (back_valid),
        .in_radicand (back_radicand),
        .in_side     (SIDE_W'(back_side)),
        .out_valid   (root_valid),
        .out_root    (corner_root),
        .out_rem     (corner_rem),
        .out_side    (corner_side_bits)
    );

    assign corner_side = setc_pkg::corner_side_t'(corner_side_bits[CSW-1:0]);

    // Resolve corner contacts: drop to apart when out of reach, else round the root.
    always_comb
    begin
        result_next = corner_side;
        if (corner_side.need_corner)
        begin
            if (corner_side.reject)
            begin
                result_next.cls      = setc_pkg::CLS_APART;
                result_next.nx       = '0;
                result_next.nz       = '0;
                result_next.distance = setc_pkg::APART_DIST;
            end
            else
            begin
                result_next.distance = $signed(corner_root
                                       + QW'(corner_rem > {1'b0, corner_root}));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= root_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_cls_reg  <= result_next.cls;
            out_nx_reg   <= result_next.nx;
            out_nz_reg   <= result_next.nz;
            out_dist_reg <= result_next.distance;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_cls_reg;
    assign m_axis_tdata  = {out_dist_reg, out_nz_reg, out_nx_reg};

    // An apart result carries the fixed distance and no normal.
    `SETC_ASSERT_IMP(a_apart_fields, out_valid_reg && (out_cls_reg == setc_pkg::CLS_APART), (out_dist_reg == setc_pkg::APART_DIST) && (out_nx_reg == '0) && (out_nz_reg == '0))
    // A deep result drops the normal.
    `SETC_ASSERT_IMP(a_deep_normal, out_valid_reg && (out_cls_reg == setc_pkg::CLS_DEEP), (out_nx_reg == '0) && (out_nz_reg == '0))
    // A touching distance is never negative.
    `SETC_ASSERT_IMP(a_touch_dist, out_valid_reg && (out_cls_reg == setc_pkg::CLS_TOUCH), !out_dist_reg[CW-1])
    // A held result freezes the tail of the pipeline.
    `SETC_ASSERT_NEXT(a_stall_hold, out_valid_reg && !m_axis_tready, $stable(root_valid) && $stable(corner_root) && $stable(back_valid))

endmodule

`default_nettype wire

/* hw/rtl/setc_isqrt.sv */
`default_nettype none

// Pipelined floor square root, one root bit per stage.
module setc_isqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [setc_pkg::RADICAND_W-1:0] in_radicand,
    input  logic [setc_pkg::SIDE_W-1:0]     in_side,
    output logic                            out_valid,
    output logic [setc_pkg::ROOT_W-1:0]     out_root,
    output logic [setc_pkg::ROOT_W:0]       out_rem,
    output logic [setc_pkg::SIDE_W-1:0]     out_side
);

    localparam int STEPS = setc_pkg::ROOT_W;
    localparam int RW    = setc_pkg::RADICAND_W;
    localparam int QW    = setc_pkg::ROOT_W;

    logic [STEPS-1:0]              valid_reg;
    logic [RW-1:0]                 rem_reg  [STEPS];
    logic [RW-1:0]                 rem_next [STEPS];
    logic [RW-1:0]                 rem_src  [STEPS];
    logic [QW-1:0]                 root_reg [STEPS];
    logic [QW-1:0]                 root_next[STEPS];
    logic [QW-1:0]                 root_src [STEPS];
    logic [setc_pkg::SIDE_W-1:0]   side_reg [STEPS];

    always_comb
    begin
        rem_src[0]  = in_radicand;
        root_src[0] = '0;
        for (int k = 1; k < STEPS; k++)
        begin
            rem_src[k]  = rem_reg[k-1];
            root_src[k] = root_reg[k-1];
        end
    end

    // trial = 2*root*2^bit + 2^(2*bit); take the bit when it fits the remainder
    always_comb
    begin
        logic [RW-1:0] trial;
        for (int k = 0; k < STEPS; k++)
        begin
            trial = (RW'(root_src[k]) << (STEPS - k)) | (RW'(1) << (2 * (STEPS - 1 - k)));
            if (rem_src[k] >= trial)
            begin
                rem_next[k]  = rem_src[k] - trial;
                root_next[k] = root_src[k] | (QW'(1) << (STEPS - 1 - k));
            end
            else
            begin
                rem_next[k]  = rem_src[k];
                root_next[k] = root_src[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[STEPS-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int k = 0; k < STEPS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
            for (int k = 1; k < STEPS; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_root  = root_reg[STEPS-1];
    assign out_rem   = rem_reg[STEPS-1][QW:0];
    assign out_side  = side_reg[STEPS-1];

endmodule

`default_nettype wire

/* hw/rtl/setc_front.sv */
`default_nettype none

// Edge deltas, magnitude normalization and squared length.
module setc_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [setc_pkg::COORD_W-1:0] center_x,
    input  logic signed [setc_pkg::COORD_W-1:0] center_z,
    input  logic [setc_pkg::RAD_W-1:0]          radius,
    input  logic signed [setc_pkg::COORD_W-1:0] start_x,
    input  logic signed [setc_pkg::COORD_W-1:0] start_z,
    input  logic signed [setc_pkg::COORD_W-1:0] end_x,
    input  logic signed [setc_pkg::COORD_W-1:0] end_z,
    output logic                                out_valid,
    output logic [setc_pkg::RADICAND_W-1:0]     out_radicand,
    output setc_pkg::len_side_t                 out_side
);

    localparam int DW = setc_pkg::DIFF_W;
    localparam int MW = setc_pkg::MAG_W;
    localparam int SW = setc_pkg::SQ_W;
    localparam int RW = setc_pkg::RADICAND_W;
    localparam int BW = setc_pkg::MSB_W;

    logic [3:0] valid_reg;

    // stage 1
    logic signed [DW-1:0]   dx_reg, dz_reg;
    logic signed [DW-1:0]   dx_next, dz_next;
    setc_pkg::edge_side_t   edge1_reg, edge1_next;
    // stage 2
    setc_pkg::edge_side_t   edge2_reg, edge3_reg, edge4_reg;
    logic [MW-1:0]          mag_x_reg, mag_z_reg, mag_x_next, mag_z_next;
    logic [MW-1:0]          mag_x3_reg, mag_z3_reg, mag_x4_reg, mag_z4_reg;
    // stage 3 and 4
    logic [SW-1:0]          sq_x_reg, sq_z_reg;
    logic [RW-1:0]          sum_reg;

    always_comb
    begin
        dx_next = DW'(end_x) - DW'(start_x);
        dz_next = DW'(end_z) - DW'(start_z);
        edge1_next.v3x    = DW'(center_x) - DW'(start_x);
        edge1_next.v3z    = DW'(center_z) - DW'(start_z);
        edge1_next.v4x    = DW'(center_x) - DW'(end_x);
        edge1_next.v4z    = DW'(center_z) - DW'(end_z);
        edge1_next.radius = radius;
        edge1_next.dx_neg = dx_next[DW-1];
        edge1_next.dz_pos = !dz_next[DW-1] && (dz_next != '0);
        edge1_next.degen  = (dx_next == '0) && (dz_next == '0);
    end

    // Scale both magnitudes by one power of two so the larger sits in [2^29, 2^31):
    // shift down when it reaches 2^31, shift up when it is below 2^29, else hold.
    always_comb
    begin
        logic [DW-1:0] abs_x;
        logic [DW-1:0] abs_z;
        logic [DW-1:0] big;
        logic [BW-1:0] msb;
        logic [RW-1:0] sh_x;
        logic [RW-1:0] sh_z;
        abs_x = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
        abs_z = dz_reg[DW-1] ? DW'(-dz_reg) : DW'(dz_reg);
        big   = (abs_x > abs_z) ? abs_x : abs_z;
        msb   = '0;
        for (int j = 0; j < DW; j++)
        begin
            if (big[j])
                msb = BW'(j);
        end
        if (msb > BW'(setc_pkg::NORM_TOP))
        begin
            sh_x = RW'(abs_x) >> (msb - BW'(setc_pkg::NORM_TOP));
            sh_z = RW'(abs_z) >> (msb - BW'(setc_pkg::NORM_TOP));
        end
        else if (msb < BW'(setc_pkg::NORM_BOT))
        begin
            sh_x = RW'(abs_x) << (BW'(setc_pkg::NORM_BOT) - msb);
            sh_z = RW'(abs_z) << (BW'(setc_pkg::NORM_BOT) - msb);
        end
        else
        begin
            sh_x = RW'(abs_x);
            sh_z = RW'(abs_z);
        end
        mag_x_next = sh_x[MW-1:0];
        mag_z_next = sh_z[MW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg     <= dx_next;
            dz_reg     <= dz_next;
            edge1_reg  <= edge1_next;
            edge2_reg  <= edge1_reg;
            mag_x_reg  <= mag_x_next;
            mag_z_reg  <= mag_z_next;
            edge3_reg  <= edge2_reg;
            mag_x3_reg <= mag_x_reg;
            mag_z3_reg <= mag_z_reg;
            sq_x_reg   <= SW'(mag_x_reg) * SW'(mag_x_reg);
            sq_z_reg   <= SW'(mag_z_reg) * SW'(mag_z_reg);
            edge4_reg  <= edge3_reg;
            mag_x4_reg <= mag_x3_reg;
            mag_z4_reg <= mag_z3_reg;
            sum_reg    <= RW'(sq_x_reg) + RW'(sq_z_reg);
        end
    end

    assign out_valid          = valid_reg[3];
    assign out_radicand       = sum_reg;
    assign out_side.edge_info = edge4_reg;
    assign out_side.mag_x     = mag_x4_reg;
    assign out_side.mag_z     = mag_z4_reg;

endmodule

`default_nettype wire

/* hw/rtl/setc_div.sv */
`default_nettype none

// Pipelined rounding divide of both magnitudes by the edge length.
module setc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [setc_pkg::ROOT_W-1:0]   in_len,
    input  setc_pkg::len_side_t           in_side,
    output logic                          out_valid,
    output logic [setc_pkg::QUO_W-1:0]    out_mx,
    output logic [setc_pkg::QUO_W-1:0]    out_mz,
    output setc_pkg::edge_side_t          out_side
);

    localparam int STAGES = setc_pkg::QUO_W + 1;
    localparam int NW     = setc_pkg::NUM_W;
    localparam int QW     = setc_pkg::QUO_W;
    localparam int LW     = setc_pkg::ROOT_W;

    logic [STAGES-1:0]      valid_reg;
    logic [NW-1:0]          rem_x_reg [STAGES], rem_x_next [STAGES];
    logic [NW-1:0]          rem_z_reg [STAGES], rem_z_next [STAGES];
    logic [QW-1:0]          q_x_reg   [STAGES], q_x_next   [STAGES];
    logic [QW-1:0]          q_z_reg   [STAGES], q_z_next   [STAGES];
    logic [LW-1:0]          div_reg   [STAGES];
    setc_pkg::edge_side_t   side_reg  [STAGES];

    // first stage forms numerators with the half-divisor rounding term
    always_comb
    begin
        logic [NW-1:0] dsh;
        rem_x_next[0] = (NW'(in_side.mag_z) << setc_pkg::FRAC_N) + NW'(in_len >> 1);
        rem_z_next[0] = (NW'(in_side.mag_x) << setc_pkg::FRAC_N) + NW'(in_len >> 1);
        q_x_next[0]   = '0;
        q_z_next[0]   = '0;
        for (int k = 1; k < STAGES; k++)
        begin
            dsh = NW'(div_reg[k-1]) << (STAGES - 1 - k);
            if (rem_x_reg[k-1] >= dsh)
            begin
                rem_x_next[k] = rem_x_reg[k-1] - dsh;
                q_x_next[k]   = q_x_reg[k-1] | (QW'(1) << (STAGES - 1 - k));
            end
            else
            begin
                rem_x_next[k] = rem_x_reg[k-1];
                q_x_next[k]   = q_x_reg[k-1];
            end
            if (rem_z_reg[k-1] >= dsh)
            begin
                rem_z_next[k] = rem_z_reg[k-1] - dsh;
                q_z_next[k]   = q_z_reg[k-1] | (QW'(1) << (STAGES - 1 - k));
            end
            else
            begin
                rem_z_next[k] = rem_z_reg[k-1];
                q_z_next[k]   = q_z_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg[0]  <= in_len;
            side_reg[0] <= in_side.edge_info;
            for (int k = 0; k < STAGES; k++)
            begin
                rem_x_reg[k] <= rem_x_next[k];
                rem_z_reg[k] <= rem_z_next[k];
                q_x_reg[k]   <= q_x_next[k];
                q_z_reg[k]   <= q_z_next[k];
            end
            for (int k = 1; k < STAGES; k++)
            begin
                div_reg[k]  <= div_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_mx    = q_x_reg[STAGES-1];
    assign out_mz    = q_z_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

`default_nettype wire

/* hw/rtl/setc_back.sv */
`default_nettype none

// Signed normal, projections, classification and corner radius test.
module setc_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [setc_pkg::QUO_W-1:0]      in_mx,
    input  logic [setc_pkg::QUO_W-1:0]      in_mz,
    input  setc_pkg::edge_side_t            in_side,
    input  logic [setc_pkg::RAD_W-1:0]      behind_margin,
    output logic                            out_valid,
    output logic [setc_pkg::RADICAND_W-1:0] out_radicand,
    output setc_pkg::corner_side_t          out_side
);

    localparam int NW  = setc_pkg::NORM_W;
    localparam int DW  = setc_pkg::DIFF_W;
    localparam int PW  = setc_pkg::PROD_W;
    localparam int JW  = setc_pkg::PROJ_W;
    localparam int XW  = setc_pkg::RND_W;
    localparam int CW  = setc_pkg::COORD_W;
    localparam int RAW = setc_pkg::RAD_W;
    localparam int SW  = setc_pkg::SQ_W;
    localparam int RW  = setc_pkg::RADICAND_W;

    logic [6:0] valid_reg;

    // stage 1: signed normal
    setc_pkg::edge_side_t   e1_reg, e2_reg, e3_reg, e4_reg;
    logic signed [NW-1:0]   nx1_reg, nz1_reg, nx2_reg, nz2_reg, nx3_reg, nz3_reg;
    logic signed [NW-1:0]   nx4_reg, nz4_reg, nx_next, nz_next;
    // stage 2: products
    logic signed [PW-1:0]   pa_reg, pb_reg, t3a_reg, t3b_reg, t4a_reg, t4b_reg;
    // stage 3: sums
    logic signed [JW-1:0]   p_raw_reg, t3_raw_reg, t4_raw_reg;
    logic signed [JW-1:0]   p_full, t3_full, t4_full;
    // stage 4: rounded projections
    logic signed [XW-1:0]   p_reg, t3_reg, t4_reg;
    // stage 5: classification
    setc_pkg::corner_side_t c5_reg, c5_next, c6_reg, c7_reg, c7_next;
    logic [RAW-1:0]         ax_reg, az_reg, r5_reg, ax_next, az_next;
    logic                   far_reg, far_next, far6_reg;
    // stage 6: squares
    logic [SW-1:0]          sqx_reg, sqz_reg, r2_reg;
    // stage 7: corner sum
    logic [RW-1:0]          sum_reg;

    always_comb
    begin
        logic signed [NW-1:0] mx;
        logic signed [NW-1:0] mz;
        mx = $signed({1'b0, in_mx});
        mz = $signed({1'b0, in_mz});
        if (in_side.degen)
        begin
            nx_next = '0;
            nz_next = '0;
        end
        else
        begin
            nx_next = in_side.dz_pos ? -mx : mx;
            nz_next = in_side.dx_neg ? -mz : mz;
        end
    end

    assign p_full  = (p_raw_reg + JW'(setc_pkg::HALF_N)) >>> setc_pkg::FRAC_N;
    assign t3_full = (t3_raw_reg + JW'(setc_pkg::HALF_N)) >>> setc_pkg::FRAC_N;
    assign t4_full = (t4_raw_reg + JW'(setc_pkg::HALF_N)) >>> setc_pkg::FRAC_N;

    always_comb
    begin
        logic signed [XW-1:0] rs;
        logic signed [XW-1:0] rm;
        logic [CW-1:0]        rsum;
        logic signed [DW-1:0] vx;
        logic signed [DW-1:0] vz;
        logic [DW-1:0]        abs_x;
        logic [DW-1:0]        abs_z;
        rs   = $signed({{(XW - RAW){1'b0}}, e4_reg.radius});
        rsum = CW'(e4_reg.radius) + CW'(behind_margin);
        rm   = $signed({{(XW - CW){1'b0}}, rsum});
        vx   = e4_reg.v4x;
        vz   = e4_reg.v4z;
        c5_next.cls         = setc_pkg::CLS_APART;
        c5_next.nx          = '0;
        c5_next.nz          = '0;
        c5_next.distance    = setc_pkg::APART_DIST;
        c5_next.need_corner = 1'b0;
        c5_next.reject      = 1'b0;
        if ((p_reg > rs) || ((p_reg > 0) && ((t3_reg < -rs) || (t4_reg > rs))))
        begin
            c5_next.cls = setc_pkg::CLS_APART;
        end
        else if (p_reg <= 0)
        begin
            // saturate behind and deep distances to the 32-bit floor
            c5_next.distance = (p_reg < XW'(setc_pkg::DIST_MIN)) ? setc_pkg::DIST_MIN
                                                                 : p_reg[CW-1:0];
            if (p_reg < -rm)
            begin
                c5_next.cls = setc_pkg::CLS_DEEP;
            end
            else
            begin
                c5_next.cls = setc_pkg::CLS_BEHIND;
                c5_next.nx  = nx4_reg;
                c5_next.nz  = nz4_reg;
            end
        end
        else
        begin
            c5_next.cls      = setc_pkg::CLS_TOUCH;
            c5_next.nx       = nx4_reg;
            c5_next.nz       = nz4_reg;
            c5_next.distance = p_reg[CW-1:0];
            if (t4_reg > 0)
            begin
                c5_next.need_corner = 1'b1;
            end
            else if (t3_reg < 0)
            begin
                c5_next.need_corner = 1'b1;
                vx = e4_reg.v3x;
                vz = e4_reg.v3z;
            end
        end
        abs_x    = vx[DW-1] ? DW'(-vx) : DW'(vx);
        abs_z    = vz[DW-1] ? DW'(-vz) : DW'(vz);
        far_next = (abs_x > DW'(e4_reg.radius)) || (abs_z > DW'(e4_reg.radius));
        ax_next  = abs_x[RAW-1:0];
        az_next  = abs_z[RAW-1:0];
    end

    // reject the corner when an offset exceeds the radius or the squared sum exceeds its square
    always_comb
    begin
        c7_next        = c6_reg;
        c7_next.reject = far6_reg || ((RW'(sqx_reg) + RW'(sqz_reg)) > RW'(r2_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[5:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg     <= in_side;
            nx1_reg    <= nx_next;
            nz1_reg    <= nz_next;

            e2_reg     <= e1_reg;
            nx2_reg    <= nx1_reg;
            nz2_reg    <= nz1_reg;
            pa_reg     <= e1_reg.v3x * nx1_reg;
            pb_reg     <= e1_reg.v3z * nz1_reg;
            t3a_reg    <= e1_reg.v3x * nz1_reg;
            t3b_reg    <= e1_reg.v3z * nx1_reg;
            t4a_reg    <= e1_reg.v4x * nz1_reg;
            t4b_reg    <= e1_reg.v4z * nx1_reg;

            e3_reg     <= e2_reg;
            nx3_reg    <= nx2_reg;
            nz3_reg    <= nz2_reg;
            p_raw_reg  <= JW'(pa_reg) + JW'(pb_reg);
            t3_raw_reg <= JW'(t3a_reg) - JW'(t3b_reg);
            t4_raw_reg <= JW'(t4a_reg) - JW'(t4b_reg);

            e4_reg     <= e3_reg;
            nx4_reg    <= nx3_reg;
            nz4_reg    <= nz3_reg;
            p_reg      <= p_full[XW-1:0];
            t3_reg     <= t3_full[XW-1:0];
            t4_reg     <= t4_full[XW-1:0];

            c5_reg     <= c5_next;
            ax_reg     <= ax_next;
            az_reg     <= az_next;
            r5_reg     <= e4_reg.radius;
            far_reg    <= far_next;

            c6_reg     <= c5_reg;
            far6_reg   <= far_reg;
            sqx_reg    <= SW'(ax_reg) * SW'(ax_reg);
            sqz_reg    <= SW'(az_reg) * SW'(az_reg);
            r2_reg     <= SW'(r5_reg) * SW'(r5_reg);

            c7_reg     <= c7_next;
            sum_reg    <= RW'(sqx_reg) + RW'(sqz_reg);
        end
    end

    assign out_valid    = valid_reg[6];
    assign out_radicand = sum_reg;
    assign out_side     = c7_reg;

endmodule

`default_nettype wire

/* bench/sphere_edge_touch_classifier_core_test.sv */
`default_nettype none

module sphere_edge_touch_classifier_core_test;

    typedef struct {
        logic signed [31:0] cx, cy, cz;
        logic [30:0]        rad;
        logic signed [31:0] sx, sz, ex, ez;
    } contact_query_t;

    typedef struct {
        setc_pkg::touch_class_t cls;
        logic signed [15:0]     nx, nz;
        logic signed [31:0]     distance;
    } contact_t;

    // Expected-contact queue plus the predictor's own copy of the margin.
    class contact_scoreboard;
        contact_t   pending[$];
        longint     margin;
        int         errors;

        function new();
            margin = 0;
            errors = 0;
        endfunction

        static function longint isqrt(longint unsigned x);
            longint unsigned res, bits;
            res = 0;
            bits = 64'd1 << 62;
            while (bits > x) bits >>= 2;
            while (bits != 0)
            begin
                if (x >= res + bits)
                begin
                    x -= res + bits;
                    res = (res >> 1) + bits;
                end
                else
                    res >>= 1;
                bits >>= 2;
            end
            return res;
        endfunction

        // Round half up by 2^14 (arithmetic shift is a floor).
        static function longint qround(longint x);
            return (x + setc_pkg::HALF_N) >>> setc_pkg::FRAC_N;
        endfunction

        static function longint corner_reach(longint vx, longint vz, longint r);
            longint ax, az, s, q;
            ax = vx < 0 ? -vx : vx;
            az = vz < 0 ? -vz : vz;
            if (ax > r || az > r) return -1;
            s = ax * ax + az * az;
            if (s > r * r) return -1;
            q = isqrt(s);
            if (s - q * q > q) q++;
            return q;
        endfunction

        function void note_query(contact_query_t q);
            longint dx, dz, a, b, m, len, nx, nz, v3x, v3z, v4x, v4z, p, t3, t4, r, c;
            contact_t e;
            dx = longint'(q.ex) - q.sx;
            dz = longint'(q.ez) - q.sz;
            a = dx < 0 ? -dx : dx;
            b = dz < 0 ? -dz : dz;
            m = a > b ? a : b;
            nx = 0;
            nz = 0;
            if (m != 0)
            begin
                while (m >= (64'sd1 << 31)) begin a >>= 1; b >>= 1; m >>= 1; end
                while (m < (64'sd1 << 29)) begin a <<= 1; b <<= 1; m <<= 1; end
                len = isqrt(a * a + b * b);
                nx = (b * 16384 + len / 2) / len;
                nz = (a * 16384 + len / 2) / len;
                if (dz > 0) nx = -nx;
                if (dx < 0) nz = -nz;
            end
            r = longint'(q.rad);
            v3x = longint'(q.cx) - q.sx;
            v3z = longint'(q.cz) - q.sz;
            v4x = longint'(q.cx) - q.ex;
            v4z = longint'(q.cz) - q.ez;
            p = qround(v3x * nx + v3z * nz);
            t3 = qround(v3x * nz - v3z * nx);
            t4 = qround(v4x * nz - v4z * nx);
            e.cls = setc_pkg::CLS_APART;
            e.distance = setc_pkg::APART_DIST;
            e.nx = 0;
            e.nz = 0;
            if (p > r || (p > 0 && t3 < -r) || (p > 0 && t4 > r))
                e.cls = setc_pkg::CLS_APART;
            else if (p <= 0)
            begin
                e.distance = p < -(64'sd1 << 31) ? setc_pkg::DIST_MIN : 32'(p);
                if (p < -(r + margin))
                    e.cls = setc_pkg::CLS_DEEP;
                else
                begin
                    e.cls = setc_pkg::CLS_BEHIND;
                    e.nx = 16'(nx);
                    e.nz = 16'(nz);
                end
            end
            else
            begin
                c = p;
                if (t4 > 0) c = corner_reach(v4x, v4z, r);
                else if (t3 < 0) c = corner_reach(v3x, v3z, r);
                if (c >= 0)
                begin
                    e.cls = setc_pkg::CLS_TOUCH;
                    e.distance = 32'(c);
                    e.nx = 16'(nx);
                    e.nz = 16'(nz);
                end
            end
            pending.push_back(e);
        endfunction

        function void check_contact(contact_t got);
            contact_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result cls=%0d nx=%0d nz=%0d distance=%0d", $time,
                         got.cls, got.nx, got.nz, got.distance);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.cls !== e.cls)
            begin
                $display("%0t: class expected %0d got %0d", $time, e.cls, got.cls);
                errors++;
            end
            if (got.nx !== e.nx)
            begin
                $display("%0t: normal_x expected %0d got %0d", $time, e.nx, got.nx);
                errors++;
            end
            if (got.nz !== e.nz)
            begin
                $display("%0t: normal_z expected %0d got %0d", $time, e.nz, got.nz);
                errors++;
            end
            if (got.distance !== e.distance)
            begin
                $display("%0t: distance expected %0d got %0d", $time, e.distance,
                         got.distance);
                errors++;
            end
        endfunction
    endclass

    localparam int PIPE_DEPTH = 92;
    localparam longint CYCLE_LIMIT = 400000;

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [30:0]  cfg_wr_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    contact_scoreboard board;
    int     send_idle_pct;
    int     recv_stall_pct;
    longint cycles;

    sphere_edge_touch_classifier_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Cycle budget: covers the slowest legal run several times over.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("sphere_edge_touch_classifier_core_test NOT OK");
            $finish;
        end
    end

    // Receiver: sample transfers at the rising edge, pick new stall at the falling edge.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            contact_t got;
            got.cls = setc_pkg::touch_class_t'(m_axis_tuser);
            got.nx = m_axis_tdata[15:0];
            got.nz = m_axis_tdata[31:16];
            got.distance = m_axis_tdata[63:32];
            board.check_contact(got);
        end
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Present one query; hold it until the transfer happens.
    task automatic send_query(contact_query_t q);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, q.ez, q.ex, q.sz, q.sx, q.rad, q.cz, q.cy, q.cx};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        board.note_query(q);
        @(negedge clk);
    endtask

    // Drain the pipe, then write the margin while the block is idle.
    task automatic drain_all();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (PIPE_DEPTH + 8) @(negedge clk);
    endtask

    task automatic set_margin(logic [30:0] value);
        drain_all();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        board.margin = longint'(value);
    endtask

    function automatic logic signed [31:0] any_coord();
        case ($urandom_range(5))
            0: return 32'sh7FFFFFFF - $urandom_range(3);
            1: return 32'sh80000000 + $urandom_range(3);
            2: return $urandom;
            default: return $signed($urandom_range(8000)) - 4000;
        endcase
    endfunction

    // Mostly near-contact geometry so every class is reached; some wild values.
    function automatic contact_query_t make_query();
        contact_query_t q;
        int scale;
        q.cy = $urandom;
        if ($urandom_range(9) == 0)
        begin
            q.cx = any_coord(); q.cz = any_coord();
            q.sx = any_coord(); q.sz = any_coord();
            q.ex = any_coord(); q.ez = any_coord();
            q.rad = 31'($urandom);
            if ($urandom_range(3) == 0) q.rad = 31'h7FFFFFFF;
            return q;
        end
        scale = 1 << $urandom_range(20);
        q.sx = $signed($urandom_range(2000)) - 1000;
        q.sz = $signed($urandom_range(2000)) - 1000;
        q.ex = $signed($urandom_range(2000)) - 1000;
        q.ez = $signed($urandom_range(2000)) - 1000;
        q.cx = $signed($urandom_range(3000)) - 1500;
        q.cz = $signed($urandom_range(3000)) - 1500;
        q.rad = 31'($urandom_range(1000));
        q.sx *= scale; q.sz *= scale; q.ex *= scale; q.ez *= scale;
        q.cx *= scale; q.cz *= scale; q.rad = 31'(q.rad * scale);
        if ($urandom_range(15) == 0) begin q.ex = q.sx; q.ez = q.sz; end
        return q;
    endfunction

    function automatic contact_query_t directed(logic signed [31:0] cx, logic signed [31:0] cz,
                                                logic [30:0] rad,
                                                logic signed [31:0] sx, logic signed [31:0] sz,
                                                logic signed [31:0] ex, logic signed [31:0] ez);
        contact_query_t q;
        q.cx = cx; q.cy = $urandom; q.cz = cz; q.rad = rad;
        q.sx = sx; q.sz = sz; q.ex = ex; q.ez = ez;
        return q;
    endfunction

    localparam logic signed [31:0] MAXC = 32'sh7FFFFFFF;
    localparam logic signed [31:0] MINC = 32'sh80000000;

    initial
    begin
        board = new();
        cycles = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: edge along +x from (0,0) to (1024,0); normal points to +z.
        send_query(directed(512, 100, 200, 0, 0, 1024, 0));         // touch on the span
        send_query(directed(512, 400, 200, 0, 0, 1024, 0));         // apart, p beyond r
        send_query(directed(512, -100, 200, 0, 0, 1024, 0));        // behind within r
        send_query(directed(512, -900, 200, 0, 0, 1024, 0));        // behind deep
        send_query(directed(1100, 50, 200, 0, 0, 1024, 0));         // end corner touch
        send_query(directed(1200, 190, 200, 0, 0, 1024, 0));        // end corner miss
        send_query(directed(-60, 60, 200, 0, 0, 1024, 0));          // start corner touch
        send_query(directed(-500, 60, 200, 0, 0, 1024, 0));         // beyond start
        send_query(directed(5, 5, 10, 77, -3, 77, -3));             // degenerate edge
        send_query(directed(0, 0, 0, 0, 0, 0, 0));                  // all zero
        send_query(directed(MAXC, MAXC, 31'h7FFFFFFF, MINC, MINC, MAXC, MAXC));
        send_query(directed(MINC, MINC, 31'h7FFFFFFF, MAXC, MAXC, MINC, MINC));
        send_query(directed(MINC, MAXC, 0, MAXC, MINC, MINC, MAXC));
        send_query(directed(MINC, MINC, 0, MAXC, MINC, MAXC, MAXC)); // apart, far on the normal side
        send_query(directed(MAXC, MINC, 31'h7FFFFFFF, MINC, MAXC, MAXC, MINC));
        send_query(directed(0, -1, 1, -1, 0, 1, 0));
        send_query(directed(3, 2, 5, 0, 0, 0, 8));                  // edge along +z

        set_margin(31'h7FFFFFFF);
        send_query(directed(512, -900, 200, 0, 0, 1024, 0));
        send_query(directed(MINC, MINC, 31'h7FFFFFFF, MAXC, MINC, MAXC, MAXC));
        set_margin(31'd300);
        send_query(directed(512, -450, 200, 0, 0, 1024, 0));
        send_query(directed(512, -550, 200, 0, 0, 1024, 0));

        // Random phases; each begins with a margin write while idle.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            case (phase)
                0: set_margin(31'd0);
                4: set_margin(31'h7FFFFFFF);
                default: set_margin(31'($urandom_range(4096) << $urandom_range(16)));
            endcase
            for (int k = 0; k < 205; k++)
            begin
                if (k == 100 && phase == 3)
                begin
                    // Let every result come home before resuming.
                    s_axis_tvalid <= 1'b0;
                    while (board.pending.size() != 0) @(negedge clk);
                end
                send_query(make_query());
            end
        end

        s_axis_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (PIPE_DEPTH + 8) @(negedge clk);
        if (board.errors == 0)
            $display("sphere_edge_touch_classifier_core_test OK");
        else
            $display("sphere_edge_touch_classifier_core_test NOT OK");
        $finish;
    end
endmodule

`default_nettype wire
